@@ rtl/x86_modrm_sib_address_unit_top_defines.svh @@
// ----------------------------------------------------------------------------
// x86 effective-address unit assertion macros
// Concurrent check wrappers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef X86_MODRM_SIB_ADDRESS_UNIT_TOP_DEFINES_SVH
`define X86_MODRM_SIB_ADDRESS_UNIT_TOP_DEFINES_SVH

// check with an explicit clock and reset
`define X86EA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("x86ea assertion failed");

// check on the local clock and reset
`define X86EA_ASSERT_RST(lbl, prop) `X86EA_ASSERT(lbl, clock, reset, prop)

`endif

@@ rtl/x86ea_pkg.sv @@
// ----------------------------------------------------------------------------
// x86ea_pkg
// Types, codes and read-port selection for the effective-address unit.
// ----------------------------------------------------------------------------
package x86ea_pkg;

   localparam int NUM_REGS  = 8;
   localparam int REG_W     = 32;
   localparam int REG_IDX_W = 3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_ADDR  = 1'b1;

   localparam logic [1:0] MOD_NODISP     = 2'd0;
   localparam logic [1:0] MOD_SHORT_DISP = 2'd1;
   localparam logic [1:0] MOD_DISPW      = 2'd2;
   localparam logic [1:0] MOD_REG        = 2'd3;

   localparam logic [2:0] RM_SIB     = 3'd4;
   localparam logic [2:0] RM_DISP32  = 3'd5;
   localparam logic [2:0] RM_DISP16  = 3'd6;
   localparam logic [2:0] SIB_NO_IDX = 3'd4;
   localparam logic [2:0] SIB_NO_BASE = 3'd5;

   localparam logic [2:0] R_EBX = 3'd3;
   localparam logic [2:0] R_EBP = 3'd5;
   localparam logic [2:0] R_ESI = 3'd6;
   localparam logic [2:0] R_EDI = 3'd7;

   localparam logic [2:0] DISP_NONE  = 3'd0;
   localparam logic [2:0] DISP_BYTE  = 3'd1;
   localparam logic [2:0] DISP_WORD  = 3'd2;
   localparam logic [2:0] DISP_DWORD = 3'd4;

   typedef struct packed {
      logic        op;
      logic [7:0]  modrm;
      logic [7:0]  sib;
      logic [31:0] disp;
      logic        addr_32;
   } s1_type;

   typedef struct packed {
      logic [31:0] address;
      logic        is_register;
      logic [2:0]  reg_number;
      logic [2:0]  disp_bytes;
      logic        uses_sib;
   } result_type;

   typedef struct packed {
      logic [REG_IDX_W-1:0] a;
      logic [REG_IDX_W-1:0] b;
   } rd_sel_type;

   function automatic rd_sel_type rd_sel(input logic [7:0] modrm, input logic [7:0] sib,
                                         input logic addr_32);
      rd_sel_type sel;
      sel.a = modrm[2:0];
      sel.b = sib[5:3];
      if (addr_32) begin
         if (modrm[2:0] == RM_SIB) begin
            sel.a = sib[2:0];
         end
      end else begin
         unique case (modrm[2:0])
            3'd0: begin sel.a = R_EBX; sel.b = R_ESI; end
            3'd1: begin sel.a = R_EBX; sel.b = R_EDI; end
            3'd2: begin sel.a = R_EBP; sel.b = R_ESI; end
            3'd3: begin sel.a = R_EBP; sel.b = R_EDI; end
            3'd4: begin sel.a = R_ESI; sel.b = R_ESI; end
            3'd5: begin sel.a = R_EDI; sel.b = R_ESI; end
            3'd6: begin sel.a = R_EBP; sel.b = R_ESI; end
            default: begin sel.a = R_EBX; sel.b = R_ESI; end
         endcase
      end
      return sel;
   endfunction

endpackage

@@ rtl/x86ea_req_if.sv @@
// ----------------------------------------------------------------------------
// x86ea_req_if
// Request channel: register writes and address transactions.
// ----------------------------------------------------------------------------
interface x86ea_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [2:0]  reg_index;
   logic [31:0] reg_value;
   logic [7:0]  modrm;
   logic [7:0]  sib;
   logic [31:0] disp;
   logic        addr_32;

   modport source (output valid, output op, output reg_index, output reg_value,
                   output modrm, output sib, output disp, output addr_32, input ready);
   modport sink   (input valid, input op, input reg_index, input reg_value,
                   input modrm, input sib, input disp, input addr_32, output ready);
endinterface

@@ rtl/x86ea_rsp_if.sv @@
// ----------------------------------------------------------------------------
// x86ea_rsp_if
// Response channel: effective address and operand decode results.
// ----------------------------------------------------------------------------
interface x86ea_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] address;
   logic        is_register;
   logic [2:0]  reg_number;
   logic [2:0]  disp_bytes;
   logic        uses_sib;

   modport source (output valid, output address, output is_register, output reg_number,
                   output disp_bytes, output uses_sib, input ready);
   modport sink   (input valid, input address, input is_register, input reg_number,
                   input disp_bytes, input uses_sib, output ready);
endinterface

@@ rtl/x86ea_regfile.sv @@
// ----------------------------------------------------------------------------
// x86ea_regfile
// Eight 32-bit general registers, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module x86ea_regfile (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [x86ea_pkg::REG_IDX_W-1:0]  wr_idx,
   input  logic [x86ea_pkg::REG_W-1:0]      wr_data,
   input  logic                             rd_en,
   input  x86ea_pkg::rd_sel_type            rd_sel,
   output logic [x86ea_pkg::REG_W-1:0]      rd_data_a,
   output logic [x86ea_pkg::REG_W-1:0]      rd_data_b
);
   import x86ea_pkg::*;

   logic [REG_W-1:0]    mem_ff [NUM_REGS];
   logic [NUM_REGS-1:0] vld_ff;
   logic [REG_W-1:0]    rd_a_ff;
   logic [REG_W-1:0]    rd_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= wr_data;
      end
   end

   // unwritten entries read as zero
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= vld_ff[rd_sel.a] ? mem_ff[rd_sel.a] : '0;
         rd_b_ff <= vld_ff[rd_sel.b] ? mem_ff[rd_sel.b] : '0;
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;
endmodule

@@ rtl/x86ea_calc.sv @@
// ----------------------------------------------------------------------------
// x86ea_calc
// ModR/M and SIB decode with base, scaled index and displacement sum.
// ----------------------------------------------------------------------------
module x86ea_calc (
   input  x86ea_pkg::s1_type             s1,
   input  logic [x86ea_pkg::REG_W-1:0]   rd_a,
   input  logic [x86ea_pkg::REG_W-1:0]   rd_b,
   output x86ea_pkg::result_type         res
);
   import x86ea_pkg::*;

   logic [1:0]  mode;
   logic [2:0]  rm;
   logic [1:0]  scale;
   logic [2:0]  idx;
   logic [2:0]  base;
   logic [31:0] base_term;
   logic [31:0] idx_term;
   logic [31:0] disp_term;
   logic [31:0] sum;
   logic [2:0]  nbytes;
   logic        regs_on;

   assign mode  = s1.modrm[7:6];
   assign rm    = s1.modrm[2:0];
   assign scale = s1.sib[7:6];
   assign idx   = s1.sib[5:3];
   assign base  = s1.sib[2:0];

   always_comb begin
      res       = '0;
      base_term = '0;
      idx_term  = '0;
      disp_term = '0;
      nbytes    = DISP_NONE;
      regs_on   = 1'b1;
      sum       = '0;
      if (s1.op == OP_ADDR) begin
         if (mode == MOD_REG) begin
            res.is_register = 1'b1;
            res.reg_number  = rm;
         end else if (s1.addr_32) begin
            if (mode == MOD_SHORT_DISP) begin
               nbytes = DISP_BYTE;
            end else if (mode == MOD_DISPW) begin
               nbytes = DISP_DWORD;
            end
            if (rm == RM_SIB) begin
               res.uses_sib = 1'b1;
               if (idx != SIB_NO_IDX) begin
                  idx_term = rd_b << scale;
               end
               if (base == SIB_NO_BASE && mode == MOD_NODISP) begin
                  nbytes = DISP_DWORD;
               end else begin
                  base_term = rd_a;
               end
            end else if (mode == MOD_NODISP && rm == RM_DISP32) begin
               nbytes = DISP_DWORD;
            end else begin
               base_term = rd_a;
            end
            if (nbytes == DISP_BYTE) begin
               disp_term = {{24{s1.disp[7]}}, s1.disp[7:0]};
            end else if (nbytes == DISP_DWORD) begin
               disp_term = s1.disp;
            end
            sum = base_term + idx_term + disp_term;
            res.address    = sum;
            res.disp_bytes = nbytes;
         end else begin
            if (mode == MOD_NODISP && rm == RM_DISP16) begin
               regs_on = 1'b0;
               nbytes  = DISP_WORD;
            end else if (mode == MOD_SHORT_DISP) begin
               nbytes = DISP_BYTE;
            end else if (mode == MOD_DISPW) begin
               nbytes = DISP_WORD;
            end
            if (regs_on) begin
               base_term = {16'h0000, rd_a[15:0]};
               if (rm[2] == 1'b0) begin
                  idx_term = {16'h0000, rd_b[15:0]};
               end
            end
            if (nbytes == DISP_BYTE) begin
               disp_term = {{24{s1.disp[7]}}, s1.disp[7:0]};
            end else if (nbytes == DISP_WORD) begin
               disp_term = {16'h0000, s1.disp[15:0]};
            end
            sum = base_term + idx_term + disp_term;
            res.address    = {16'h0000, sum[15:0]};
            res.disp_bytes = nbytes;
         end
      end
   end
endmodule

@@ rtl/x86_modrm_sib_address_unit_top.sv @@
// ----------------------------------------------------------------------------
// x86_modrm_sib_address_unit_top: register file with x86 effective-address unit
// The register-file read is registered at accept, then the address sum in the output register.
// Throughput one transaction per cycle while rsp_ch.ready does not stall the output register.
// Synchronous reset clears pipeline valids and marks all registers zero.
// ----------------------------------------------------------------------------
`include "x86_modrm_sib_address_unit_top_defines.svh"

module x86_modrm_sib_address_unit_top (
   input logic          clock,
   input logic          reset,
   x86ea_req_if.sink    req_ch,
   x86ea_rsp_if.source  rsp_ch
);
   import x86ea_pkg::*;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   s1_type     s1_ff;
   s1_type     s1_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   result_type out_ff;
   result_type calc_res;
   rd_sel_type sel;
   logic       advance;
   logic       req_fire;
   logic [REG_W-1:0] rd_a;
   logic [REG_W-1:0] rd_b;
   logic       reg_form_clean;
   logic       disp_legal;

   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign sel          = rd_sel(req_ch.modrm, req_ch.sib, req_ch.addr_32);

   assign s1_in.op      = req_ch.op;
   assign s1_in.modrm   = req_ch.modrm;
   assign s1_in.sib     = req_ch.sib;
   assign s1_in.disp    = req_ch.disp;
   assign s1_in.addr_32 = req_ch.addr_32;

   x86ea_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (req_fire && req_ch.op == OP_WRITE),
      .wr_idx    (req_ch.reg_index),
      .wr_data   (req_ch.reg_value),
      .rd_en     (req_fire),
      .rd_sel    (sel),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   x86ea_calc u_calc (
      .s1   (s1_ff),
      .rd_a (rd_a),
      .rd_b (rd_b),
      .res  (calc_res)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      if (advance) begin
         out_ff <= calc_res;
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.address     = out_ff.address;
   assign rsp_ch.is_register = out_ff.is_register;
   assign rsp_ch.reg_number  = out_ff.reg_number;
   assign rsp_ch.disp_bytes  = out_ff.disp_bytes;
   assign rsp_ch.uses_sib    = out_ff.uses_sib;

   assign reg_form_clean = out_ff.address == '0 && out_ff.disp_bytes == DISP_NONE &&
                           !out_ff.uses_sib;
   assign disp_legal     = out_ff.disp_bytes == DISP_NONE || out_ff.disp_bytes == DISP_BYTE ||
                           out_ff.disp_bytes == DISP_WORD || out_ff.disp_bytes == DISP_DWORD;

   `X86EA_ASSERT_RST(a_s1_hold, s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_ff))
   `X86EA_ASSERT_RST(a_fire_fills, req_fire |=> s1_valid_ff)
   `X86EA_ASSERT_RST(a_reg_form, out_valid_ff && out_ff.is_register |-> reg_form_clean)
   `X86EA_ASSERT_RST(a_disp_legal, out_valid_ff |-> disp_legal)
endmodule
